[src/gph_pkg.sv]
// Package for the grid photon histogram: transaction payload structs,
// register indexes, status codes and field widths.
// No dependencies.
`default_nettype none

package gph_pkg;

  localparam int unsigned WEIGHT_W   = 32;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned DIST_W     = 24;
  localparam int unsigned SEL_W      = 6;
  localparam int unsigned BIN_PH_W   = 48;
  localparam int unsigned BIN_HIT_W  = 32;
  localparam int unsigned TOT_PH_W   = 56;
  localparam int unsigned TOT_CNT_W  = 32;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = DIST_W;
  localparam int unsigned BIN_WORD_W = BIN_PH_W + BIN_HIT_W;

  // Largest count that a 7-bit count register can hold.
  localparam int unsigned CNT_MAX    = (1 << CNT_W) - 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_COLUMNS   = 3'd0,
    REG_GRID_ROWS      = 3'd1,
    REG_COLUMN_SPACING = 3'd2,
    REG_ROW_SPACING    = 3'd3,
    REG_MIRROR_WIDTH   = 3'd4,
    REG_MIRROR_HEIGHT  = 3'd5
  } cfg_reg_e;

  localparam logic [STATUS_W-1:0] ST_COUNTED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE_X = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE_Y = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READ_OK   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_READ_BAD  = 3'd5;

  localparam logic OP_PHOTON = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef struct packed {
    logic                    operation;
    logic [WEIGHT_W-1:0]     photon_weight;
    logic signed [POS_W-1:0] x_position;
    logic signed [POS_W-1:0] y_position;
    logic [SEL_W-1:0]        read_column;
    logic [SEL_W-1:0]        read_row;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [BIN_PH_W-1:0]  bin_photons;
    logic [BIN_HIT_W-1:0] bin_hits;
    logic [TOT_PH_W-1:0]  total_photons;
    logic [TOT_CNT_W-1:0] total_hits;
    logic [TOT_CNT_W-1:0] outside_x_count;
    logic [TOT_CNT_W-1:0] outside_y_count;
    logic [TOT_CNT_W-1:0] records_seen;
  } result_t;

endpackage

`default_nettype wire

[src/gph_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered. No dependencies.
`default_nettype none

module gph_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[src/grid_photon_histogram.sv]
// Two-dimensional photon histogram over a grid of mirrors: bins in one RAM,
// running totals in registers. Depends on gph_pkg and gph_ram.
//
// Channel   Ports                                  Direction  Handshake
// item      start, busy, item_i                    in         start & !busy
// result    done_o, result_o                       out        done_o strobe, one cycle
// config    cfg_we_i, cfg_idx_i, cfg_wdata_i       in         cfg_we_i, no wait
//
// After reset the bin RAM is cleared one entry a cycle, all MAX_COLUMNS*MAX_ROWS
// entries (4096 by default), with busy high. A photon record steps through
// S_MUL, S_SUM, S_CMP, the 7-step quotient iteration in S_DIV, and S_IDX; one that
// lands in a bin goes on to the RAM read (S_RD) and write-back (S_WB), one outside
// the grid ends at S_IDX. A read goes through S_RD and S_WB; an ignored weight or a
// bad read index gives its result in the next cycle. One transaction is in work at
// a time, and the next start is taken in the cycle the result strobe is high.
`default_nettype none

module grid_photon_histogram #(
  parameter int unsigned MAX_COLUMNS = 64,
  parameter int unsigned MAX_ROWS    = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire gph_pkg::item_t                   item_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [gph_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [gph_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output logic                                  done_o,
  output gph_pkg::result_t                      result_o
);

  import gph_pkg::*;

  localparam int unsigned DEPTH   = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned COL_CAP = (MAX_COLUMNS < CNT_MAX) ? MAX_COLUMNS : CNT_MAX;
  localparam int unsigned ROW_CAP = (MAX_ROWS < CNT_MAX) ? MAX_ROWS : CNT_MAX;
  localparam int unsigned HALF_W  = CNT_W - 1;
  localparam int unsigned PROD_W  = DIST_W + HALF_W;
  localparam int unsigned LIM_W   = DIST_W + CNT_W;
  localparam int unsigned NUM_W   = POS_W + 3;
  localparam int unsigned STEP_W  = $clog2(CNT_W);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLEAR = 9'b000000010,
    S_MUL   = 9'b000000100,
    S_SUM   = 9'b000001000,
    S_CMP   = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_IDX   = 9'b001000000,
    S_RD    = 9'b010000000,
    S_WB    = 9'b100000000
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [CNT_W-1:0]  cols_q, rows_q;
  logic [DIST_W-1:0] col_sp_q, row_sp_q, mir_w_q, mir_h_q;

  // Running totals.
  logic [TOT_PH_W-1:0]  ph_tot_q;
  logic [TOT_CNT_W-1:0] hit_tot_q, rej_x_q, rej_y_q, rec_q;

  // Datapath registers.
  item_t              item_q;
  logic [PROD_W-1:0]  prod_x_q, prod_y_q;
  logic [LIM_W-1:0]   lim_x_q, lim_y_q;
  logic [NUM_W-1:0]   num_x_q, num_y_q;
  logic               out_x_q, out_y_q;
  logic [LIM_W-1:0]   rem_x_q, rem_y_q;
  logic [CNT_W-1:0]   quo_x_q, quo_y_q;
  logic [STEP_W-1:0]  step_q;
  logic [AW-1:0]      addr_q, clr_q;
  logic               done_q;
  logic [STATUS_W-1:0]  res_status_q;
  logic [BIN_PH_W-1:0]  res_ph_q;
  logic [BIN_HIT_W-1:0] res_hit_q;

  logic [CNT_W-1:0]  n_col, n_row;
  logic [DIST_W-1:0] div_x, div_y;
  logic              accept, rd_in_range;
  logic [LIM_W-1:0]  trial_x, trial_y;
  logic              ge_x, ge_y;
  logic [NUM_W-1:0]  num_x_d, num_y_d;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr;
  logic [BIN_WORD_W-1:0] ram_wdata, ram_rdata;
  logic [BIN_PH_W-1:0]   old_ph, new_ph;
  logic [BIN_HIT_W-1:0]  old_hit, new_hit;
  logic [BIN_PH_W:0]     ph_sum;
  logic [TOT_PH_W:0]     tot_sum;
  logic [TOT_PH_W-1:0]   tot_new;

  // A count of zero acts as one; counts above the grid size saturate.
  always_comb begin
    if (cols_q == '0) begin
      n_col = CNT_W'(1);
    end else if (cols_q > CNT_W'(COL_CAP)) begin
      n_col = CNT_W'(COL_CAP);
    end else begin
      n_col = cols_q;
    end
    if (rows_q == '0) begin
      n_row = CNT_W'(1);
    end else if (rows_q > CNT_W'(ROW_CAP)) begin
      n_row = CNT_W'(ROW_CAP);
    end else begin
      n_row = rows_q;
    end
  end

  assign div_x = (col_sp_q == '0) ? DIST_W'(1) : col_sp_q;
  assign div_y = (row_sp_q == '0) ? DIST_W'(1) : row_sp_q;

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign rd_in_range = ({1'b0, item_i.read_column} < n_col)
                    && ({1'b0, item_i.read_row} < n_row);

  // Numerator: position plus grid offset plus mirror extent, signed.
  assign num_x_d = {{(NUM_W-POS_W){item_q.x_position[POS_W-1]}}, item_q.x_position}
                 + NUM_W'(prod_x_q) + NUM_W'(mir_w_q);
  assign num_y_d = {{(NUM_W-POS_W){item_q.y_position[POS_W-1]}}, item_q.y_position}
                 + NUM_W'(prod_y_q) + NUM_W'(mir_h_q);

  // Restoring division; the range check has already bounded the quotient
  // below 2**CNT_W, so only CNT_W steps are needed.
  assign trial_x = LIM_W'(div_x) << step_q;
  assign trial_y = LIM_W'(div_y) << step_q;
  assign ge_x    = (rem_x_q >= trial_x);
  assign ge_y    = (rem_y_q >= trial_y);

  // Bin update arithmetic, saturating.
  assign old_ph  = ram_rdata[BIN_PH_W-1:0];
  assign old_hit = ram_rdata[BIN_WORD_W-1:BIN_PH_W];
  assign ph_sum  = {1'b0, old_ph} + (BIN_PH_W+1)'(item_q.photon_weight);
  assign new_ph  = ph_sum[BIN_PH_W] ? '1 : ph_sum[BIN_PH_W-1:0];
  assign new_hit = (old_hit == '1) ? old_hit : old_hit + BIN_HIT_W'(1);
  assign tot_sum = {1'b0, ph_tot_q} + (TOT_PH_W+1)'(item_q.photon_weight);
  assign tot_new = tot_sum[TOT_PH_W] ? '1 : tot_sum[TOT_PH_W-1:0];

  assign ram_we    = (state_q == S_CLEAR) || ((state_q == S_WB) && (item_q.operation == OP_PHOTON));
  assign ram_waddr = (state_q == S_CLEAR) ? clr_q : addr_q;
  assign ram_wdata = (state_q == S_CLEAR) ? '0 : {new_hit, new_ph};
  assign ram_re    = (state_q == S_RD);

  gph_ram #(
    .WIDTH (BIN_WORD_W),
    .DEPTH (DEPTH)
  ) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // Control state, configuration and totals.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      step_q    <= '0;
      done_q    <= 1'b0;
      cols_q    <= CNT_W'(1);
      rows_q    <= CNT_W'(1);
      col_sp_q  <= DIST_W'(16);
      row_sp_q  <= DIST_W'(16);
      mir_w_q   <= '0;
      mir_h_q   <= '0;
      ph_tot_q  <= '0;
      hit_tot_q <= '0;
      rej_x_q   <= '0;
      rej_y_q   <= '0;
      rec_q     <= '0;
    end else begin
      done_q <= 1'b0;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GRID_COLUMNS:   cols_q   <= cfg_wdata_i[CNT_W-1:0];
          REG_GRID_ROWS:      rows_q   <= cfg_wdata_i[CNT_W-1:0];
          REG_COLUMN_SPACING: col_sp_q <= cfg_wdata_i;
          REG_ROW_SPACING:    row_sp_q <= cfg_wdata_i;
          REG_MIRROR_WIDTH:   mir_w_q  <= cfg_wdata_i;
          REG_MIRROR_HEIGHT:  mir_h_q  <= cfg_wdata_i;
          default: ;
        endcase
      end

      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (item_i.operation == OP_READ) begin
              if (rd_in_range) begin
                state_q <= S_RD;
              end else begin
                done_q <= 1'b1;
              end
            end else begin
              if (rec_q != '1) begin
                rec_q <= rec_q + TOT_CNT_W'(1);
              end
              if (item_i.photon_weight == '0) begin
                done_q <= 1'b1;
              end else begin
                state_q <= S_MUL;
              end
            end
          end
        end
        S_MUL: state_q <= S_SUM;
        S_SUM: state_q <= S_CMP;
        S_CMP: begin
          step_q  <= STEP_W'(CNT_W - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (step_q == '0) begin
            state_q <= S_IDX;
          end else begin
            step_q <= step_q - STEP_W'(1);
          end
        end
        S_IDX: begin
          // The x check comes first: a record outside on both axes counts as x.
          if (out_x_q) begin
            if (rej_x_q != '1) begin
              rej_x_q <= rej_x_q + TOT_CNT_W'(1);
            end
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else if (out_y_q) begin
            if (rej_y_q != '1) begin
              rej_y_q <= rej_y_q + TOT_CNT_W'(1);
            end
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_RD;
          end
        end
        S_RD: state_q <= S_WB;
        S_WB: begin
          if (item_q.operation == OP_PHOTON) begin
            ph_tot_q <= tot_new;
            if (hit_tot_q != '1) begin
              hit_tot_q <= hit_tot_q + TOT_CNT_W'(1);
            end
          end
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_q    <= item_i;
          addr_q    <= AW'(32'(item_i.read_column) * 32'(MAX_ROWS) + 32'(item_i.read_row));
          res_ph_q  <= '0;
          res_hit_q <= '0;
          if (item_i.operation == OP_READ) begin
            res_status_q <= ST_READ_BAD;
          end else begin
            res_status_q <= ST_IGNORED;
          end
        end
      end
      S_MUL: begin
        prod_x_q <= PROD_W'(col_sp_q) * PROD_W'(n_col[CNT_W-1:1]);
        prod_y_q <= PROD_W'(row_sp_q) * PROD_W'(n_row[CNT_W-1:1]);
        lim_x_q  <= LIM_W'(div_x) * LIM_W'(n_col);
        lim_y_q  <= LIM_W'(div_y) * LIM_W'(n_row);
      end
      S_SUM: begin
        num_x_q <= num_x_d;
        num_y_q <= num_y_d;
      end
      S_CMP: begin
        // A negative numerator floors to a negative index, which is outside.
        out_x_q <= num_x_q[NUM_W-1] || (num_x_q[NUM_W-2:0] >= (NUM_W-1)'(lim_x_q));
        out_y_q <= num_y_q[NUM_W-1] || (num_y_q[NUM_W-2:0] >= (NUM_W-1)'(lim_y_q));
        rem_x_q <= num_x_q[LIM_W-1:0];
        rem_y_q <= num_y_q[LIM_W-1:0];
        quo_x_q <= '0;
        quo_y_q <= '0;
      end
      S_DIV: begin
        if (ge_x) begin
          rem_x_q <= rem_x_q - trial_x;
        end
        if (ge_y) begin
          rem_y_q <= rem_y_q - trial_y;
        end
        quo_x_q <= {quo_x_q[CNT_W-2:0], ge_x};
        quo_y_q <= {quo_y_q[CNT_W-2:0], ge_y};
      end
      S_IDX: begin
        addr_q <= AW'(32'(quo_x_q) * 32'(MAX_ROWS) + 32'(quo_y_q));
        if (out_x_q) begin
          res_status_q <= ST_OUTSIDE_X;
        end else begin
          res_status_q <= ST_OUTSIDE_Y;
        end
      end
      S_WB: begin
        if (item_q.operation == OP_READ) begin
          res_status_q <= ST_READ_OK;
          res_ph_q     <= old_ph;
          res_hit_q    <= old_hit;
        end else begin
          res_status_q <= ST_COUNTED;
          res_ph_q     <= new_ph;
          res_hit_q    <= new_hit;
        end
      end
      default: ;
    endcase
  end

  assign done_o                   = done_q;
  assign result_o.status          = res_status_q;
  assign result_o.bin_photons     = res_ph_q;
  assign result_o.bin_hits        = res_hit_q;
  assign result_o.total_photons   = ph_tot_q;
  assign result_o.total_hits      = hit_tot_q;
  assign result_o.outside_x_count = rej_x_q;
  assign result_o.outside_y_count = rej_y_q;
  assign result_o.records_seen    = rec_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register is not one-hot");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || done_q))
    else $error("accepted transaction neither in work nor finished");

  a_records_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (rec_q >= $past(rec_q)) && (hit_tot_q >= $past(hit_tot_q)))
    else $error("record or hit total went down");

  a_counted_has_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (res_status_q == ST_COUNTED)) |-> (res_hit_q != '0) && (hit_tot_q != '0))
    else $error("counted record reports no hit");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ram_we)
    else $error("bin RAM written while idle");

endmodule

`default_nettype wire

[bench/tb_grid_photon_histogram.sv]
`timescale 1ns / 1ps
// Testbench for grid_photon_histogram: a directed stimulus table, then random
// grid setups; each result is checked against its table value or a behavioral
// histogram model. Depends on gph_pkg and the grid_photon_histogram RTL.

module tb_grid_photon_histogram;
  import gph_pkg::*;

  localparam int unsigned GRID_MAX_COLS = 64;
  localparam int unsigned GRID_MAX_ROWS = 64;
  localparam int unsigned PHASE_ITEMS   = 205;
  localparam int unsigned NUM_PHASES    = 8;

  typedef struct {
    item_t   item;
    bit      typed;
    result_t want;
  } stim_row_t;

  typedef struct {
    logic [DIST_W-1:0] columns;
    logic [DIST_W-1:0] rows;
    logic [DIST_W-1:0] col_pitch;
    logic [DIST_W-1:0] row_pitch;
    logic [DIST_W-1:0] x_extent;
    logic [DIST_W-1:0] y_extent;
  } grid_setup_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  item_t                 item_i;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  done_o;
  result_t               result_o;

  // Shadow copy of the grid registers and the histogram contents.
  logic [CNT_W-1:0]     m_columns;
  logic [CNT_W-1:0]     m_rows;
  logic [DIST_W-1:0]    m_col_pitch;
  logic [DIST_W-1:0]    m_row_pitch;
  logic [DIST_W-1:0]    m_x_extent;
  logic [DIST_W-1:0]    m_y_extent;
  logic [BIN_PH_W-1:0]  bin_photon_sum [GRID_MAX_COLS*GRID_MAX_ROWS];
  logic [BIN_HIT_W-1:0] bin_hit_sum [GRID_MAX_COLS*GRID_MAX_ROWS];
  logic [TOT_PH_W-1:0]  photon_sum;
  logic [TOT_CNT_W-1:0] hit_count;
  logic [TOT_CNT_W-1:0] reject_x_count;
  logic [TOT_CNT_W-1:0] reject_y_count;
  logic [TOT_CNT_W-1:0] record_count;

  result_t     awaited_results[$];
  stim_row_t   directed_rows[$];
  grid_setup_t phase_plan [NUM_PHASES];
  int unsigned mismatch_count;
  bit          no_gaps;

  grid_photon_histogram dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, int unsigned w);
    logic [63:0] ceiling;
    ceiling = (64'd1 << w) - 64'd1;
    return (a + b > ceiling) ? ceiling : a + b;
  endfunction

  // A zero count acts as one, and counts above the store size are clipped.
  function automatic int unsigned effective_count(logic [CNT_W-1:0] n, int unsigned cap);
    if (n == 0) return 1;
    return (n > cap) ? cap : n;
  endfunction

  // Bin index along one axis, or -1 when the hit falls outside the grid.
  function automatic int axis_slot(logic [POS_W-1:0] pos, logic [DIST_W-1:0] pitch,
                                   logic [DIST_W-1:0] extent, int unsigned n);
    longint num;
    longint divisor;
    longint half;
    longint quot;
    half = n / 2;
    num = longint'($signed(pos)) + longint'(pitch) * half + longint'(extent);
    divisor = (pitch == 0) ? 64'sd1 : longint'(pitch);
    if (num < 0) return -1;
    quot = num / divisor;
    if (quot >= longint'(n)) return -1;
    return int'(quot);
  endfunction

  function automatic result_t histogram_step(item_t it);
    result_t     r;
    int unsigned ncol;
    int unsigned nrow;
    int          col;
    int          row;
    int          bin;
    ncol = effective_count(m_columns, GRID_MAX_COLS);
    nrow = effective_count(m_rows, GRID_MAX_ROWS);
    r = '0;
    if (it.operation == OP_READ) begin
      if (it.read_column < ncol && it.read_row < nrow) begin
        bin = it.read_column * GRID_MAX_ROWS + it.read_row;
        r.status = ST_READ_OK;
        r.bin_photons = bin_photon_sum[bin];
        r.bin_hits = bin_hit_sum[bin];
      end else begin
        r.status = ST_READ_BAD;
      end
    end else begin
      record_count = sat_add(record_count, 1, TOT_CNT_W);
      if (it.photon_weight == 0) begin
        r.status = ST_IGNORED;
      end else begin
        col = axis_slot(it.x_position, m_col_pitch, m_x_extent, ncol);
        row = axis_slot(it.y_position, m_row_pitch, m_y_extent, nrow);
        // The x test wins when a hit misses the grid on both axes.
        if (col < 0) begin
          r.status = ST_OUTSIDE_X;
          reject_x_count = sat_add(reject_x_count, 1, TOT_CNT_W);
        end else if (row < 0) begin
          r.status = ST_OUTSIDE_Y;
          reject_y_count = sat_add(reject_y_count, 1, TOT_CNT_W);
        end else begin
          bin = col * GRID_MAX_ROWS + row;
          r.status = ST_COUNTED;
          bin_photon_sum[bin] = sat_add(bin_photon_sum[bin], it.photon_weight, BIN_PH_W);
          bin_hit_sum[bin] = sat_add(bin_hit_sum[bin], 1, BIN_HIT_W);
          photon_sum = sat_add(photon_sum, it.photon_weight, TOT_PH_W);
          hit_count = sat_add(hit_count, 1, TOT_CNT_W);
          r.bin_photons = bin_photon_sum[bin];
          r.bin_hits = bin_hit_sum[bin];
        end
      end
    end
    r.total_photons = photon_sum;
    r.total_hits = hit_count;
    r.outside_x_count = reject_x_count;
    r.outside_y_count = reject_y_count;
    r.records_seen = record_count;
    return r;
  endfunction

  task automatic check_result(result_t want, result_t got);
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      mismatch_count++;
    end
    if (got.bin_photons !== want.bin_photons) begin
      $error("bin_photons: expected %0h, actual %0h", want.bin_photons, got.bin_photons);
      mismatch_count++;
    end
    if (got.bin_hits !== want.bin_hits) begin
      $error("bin_hits: expected %0d, actual %0d", want.bin_hits, got.bin_hits);
      mismatch_count++;
    end
    if (got.total_photons !== want.total_photons) begin
      $error("total_photons: expected %0h, actual %0h", want.total_photons,
             got.total_photons);
      mismatch_count++;
    end
    if (got.total_hits !== want.total_hits) begin
      $error("total_hits: expected %0d, actual %0d", want.total_hits, got.total_hits);
      mismatch_count++;
    end
    if (got.outside_x_count !== want.outside_x_count) begin
      $error("outside_x_count: expected %0d, actual %0d", want.outside_x_count,
             got.outside_x_count);
      mismatch_count++;
    end
    if (got.outside_y_count !== want.outside_y_count) begin
      $error("outside_y_count: expected %0d, actual %0d", want.outside_y_count,
             got.outside_y_count);
      mismatch_count++;
    end
    if (got.records_seen !== want.records_seen) begin
      $error("records_seen: expected %0d, actual %0d", want.records_seen, got.records_seen);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $error("result strobe with no transaction outstanding");
        mismatch_count++;
      end else begin
        check_result(awaited_results.pop_front(), result_o);
      end
    end
  end

  function automatic item_t mk_item(logic op, logic [WEIGHT_W-1:0] w, logic [POS_W-1:0] x,
                                    logic [POS_W-1:0] y, logic [SEL_W-1:0] c,
                                    logic [SEL_W-1:0] r);
    item_t it;
    it.operation = op;
    it.photon_weight = w;
    it.x_position = x;
    it.y_position = y;
    it.read_column = c;
    it.read_row = r;
    return it;
  endfunction

  function automatic result_t mk_result(logic [STATUS_W-1:0] st, logic [BIN_PH_W-1:0] bph,
                                        logic [BIN_HIT_W-1:0] bh, logic [TOT_PH_W-1:0] tph,
                                        logic [TOT_CNT_W-1:0] th, logic [TOT_CNT_W-1:0] ox,
                                        logic [TOT_CNT_W-1:0] oy, logic [TOT_CNT_W-1:0] rec);
    result_t r;
    r.status = st;
    r.bin_photons = bph;
    r.bin_hits = bh;
    r.total_photons = tph;
    r.total_hits = th;
    r.outside_x_count = ox;
    r.outside_y_count = oy;
    r.records_seen = rec;
    return r;
  endfunction

  function automatic void add_row(item_t it, bit typed, result_t want);
    stim_row_t row;
    row.item = it;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [WEIGHT_W-1:0] random_weight();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return $urandom_range(1, 255);
      default: return $urandom;
    endcase
  endfunction

  // Slots just outside the grid and at its first and last lane.
  function automatic int border_slot(int unsigned n);
    case ($urandom_range(0, 3))
      0: return -1;
      1: return 0;
      2: return int'(n) - 1;
      default: return int'(n);
    endcase
  endfunction

  // A position that lands in the given slot, near either end or anywhere inside.
  function automatic logic [POS_W-1:0] axis_point(int slot, logic [DIST_W-1:0] pitch,
                                                  logic [DIST_W-1:0] extent, int unsigned n);
    longint pitch_eff;
    longint half;
    longint base;
    longint offs;
    logic [POS_W-1:0] pos;
    pitch_eff = (pitch == 0) ? 64'sd1 : longint'(pitch);
    half = n / 2;
    base = longint'(slot) * pitch_eff - longint'(pitch) * half - longint'(extent);
    case ($urandom_range(0, 3))
      0: offs = 0;
      1: offs = pitch_eff - 1;
      default: offs = $urandom_range(0, pitch_eff - 1);
    endcase
    pos = base + offs;
    return pos;
  endfunction

  function automatic item_t random_item();
    item_t       it;
    int unsigned ncol;
    int unsigned nrow;
    int unsigned pick;
    int          col;
    int          row;
    ncol = effective_count(m_columns, GRID_MAX_COLS);
    nrow = effective_count(m_rows, GRID_MAX_ROWS);
    it.operation = OP_PHOTON;
    it.photon_weight = random_weight();
    it.x_position = $urandom;
    it.y_position = $urandom;
    it.read_column = $urandom;
    it.read_row = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      it.operation = OP_READ;
      if (pick < 17) begin
        it.read_column = $urandom_range(0, ncol - 1);
        it.read_row = $urandom_range(0, nrow - 1);
      end
    end else if (pick < 24) begin
      it.photon_weight = '0;
    end else if (pick >= 32) begin
      // Most records are aimed at the grid; some at its borders.
      col = $urandom_range(0, ncol - 1);
      row = $urandom_range(0, nrow - 1);
      if (pick < 44) begin
        col = border_slot(ncol);
        row = border_slot(nrow);
      end
      it.x_position = axis_point(col, m_col_pitch, m_x_extent, ncol);
      it.y_position = axis_point(row, m_row_pitch, m_y_extent, nrow);
    end
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(item_t it, bit typed, result_t want);
    int unsigned gap;
    result_t     predicted;
    if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
    predicted = histogram_step(it);
    awaited_results.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      REG_GRID_COLUMNS:   m_columns = value[CNT_W-1:0];
      REG_GRID_ROWS:      m_rows = value[CNT_W-1:0];
      REG_COLUMN_SPACING: m_col_pitch = value;
      REG_ROW_SPACING:    m_row_pitch = value;
      REG_MIRROR_WIDTH:   m_x_extent = value;
      REG_MIRROR_HEIGHT:  m_y_extent = value;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Registers change only once the block has drained every transaction.
  task automatic apply_setup(grid_setup_t s);
    start <= 1'b0;
    while (awaited_results.size() != 0 || busy !== 1'b0) @(negedge clk_i);
    write_reg(REG_GRID_COLUMNS, s.columns);
    write_reg(REG_GRID_ROWS, s.rows);
    write_reg(REG_COLUMN_SPACING, s.col_pitch);
    write_reg(REG_ROW_SPACING, s.row_pitch);
    write_reg(REG_MIRROR_WIDTH, s.x_extent);
    write_reg(REG_MIRROR_HEIGHT, s.y_extent);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned p;
    logic [BIN_PH_W-1:0] big;
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    no_gaps        = 1'b0;
    mismatch_count = 0;

    m_columns   = 1;
    m_rows      = 1;
    m_col_pitch = 16;
    m_row_pitch = 16;
    m_x_extent  = 0;
    m_y_extent  = 0;
    foreach (bin_photon_sum[i]) begin
      bin_photon_sum[i] = '0;
      bin_hit_sum[i] = '0;
    end
    photon_sum     = '0;
    hit_count      = '0;
    reject_x_count = '0;
    reject_y_count = '0;
    record_count   = '0;

    // Reset grid is one 16 x 16 cell at the origin, so only 0..15 lands inside.
    big = 48'h1_0000_0000;
    add_row(mk_item(OP_READ, 0, 0, 0, 0, 0), 1,
            mk_result(ST_READ_OK, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_item(OP_READ, 0, 0, 0, 63, 63), 1,
            mk_result(ST_READ_BAD, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_item(OP_READ, 0, 0, 0, 1, 0), 1,
            mk_result(ST_READ_BAD, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_item(OP_READ, 0, 0, 0, 0, 1), 1,
            mk_result(ST_READ_BAD, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_item(OP_PHOTON, 0, 0, 0, 0, 0), 1,
            mk_result(ST_IGNORED, 0, 0, 0, 0, 0, 0, 1));
    add_row(mk_item(OP_PHOTON, 1, 0, 0, 0, 0), 1,
            mk_result(ST_COUNTED, 1, 1, 1, 1, 0, 0, 2));
    add_row(mk_item(OP_PHOTON, 32'hFFFF_FFFF, 15, 15, 0, 0), 1,
            mk_result(ST_COUNTED, big, 2, big, 2, 0, 0, 3));
    add_row(mk_item(OP_PHOTON, 5, 16, 0, 0, 0), 1,
            mk_result(ST_OUTSIDE_X, 0, 0, big, 2, 1, 0, 4));
    add_row(mk_item(OP_PHOTON, 5, 32'hFFFF_FFFF, 0, 0, 0), 1,
            mk_result(ST_OUTSIDE_X, 0, 0, big, 2, 2, 0, 5));
    add_row(mk_item(OP_PHOTON, 5, 0, 16, 0, 0), 1,
            mk_result(ST_OUTSIDE_Y, 0, 0, big, 2, 2, 1, 6));
    add_row(mk_item(OP_PHOTON, 5, 32'h8000_0000, 32'h8000_0000, 0, 0), 1,
            mk_result(ST_OUTSIDE_X, 0, 0, big, 2, 3, 1, 7));
    add_row(mk_item(OP_PHOTON, 7, 32'h7FFF_FFFF, 0, 0, 0), 1,
            mk_result(ST_OUTSIDE_X, 0, 0, big, 2, 4, 1, 8));
    add_row(mk_item(OP_PHOTON, 7, 0, 32'h7FFF_FFFF, 0, 0), 1,
            mk_result(ST_OUTSIDE_Y, 0, 0, big, 2, 4, 2, 9));
    add_row(mk_item(OP_PHOTON, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 63, 63), 1,
            mk_result(ST_IGNORED, 0, 0, big, 2, 4, 2, 10));
    add_row(mk_item(OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0), 1,
            mk_result(ST_READ_OK, big, 2, big, 2, 4, 2, 10));
    add_row(mk_item(OP_PHOTON, 32'h8000_0000, 8, 8, 63, 63), 0, '0);
    add_row(mk_item(OP_PHOTON, 32'h0000_FFFF, 0, 32'hFFFF_FFFF, 0, 0), 0, '0);

    // Zero counts, clipped counts, zero and full spacings, full mirror offsets.
    phase_plan[0] = '{24'd0, 24'd0, 24'd1, 24'd0, 24'd0, 24'd0};
    phase_plan[1] = '{24'd64, 24'd64, 24'd16, 24'd16, 24'd0, 24'd0};
    phase_plan[2] = '{24'd127, 24'd100, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF};
    phase_plan[3] = '{24'd7, 24'd13, 24'd0, 24'd3, 24'd5, 24'd100};
    phase_plan[4] = '{24'd2, 24'd1, 24'd1, 24'd1, 24'hFF_FFFF, 24'd0};
    phase_plan[5] = '{24'd65, 24'd1, 24'd40, 24'd0, 24'd0, 24'hFF_FFFF};
    for (p = 6; p < NUM_PHASES; p++) begin
      // Bits above the count width carry noise that the block must drop.
      phase_plan[p].columns = ($urandom << CNT_W) | $urandom_range(1, GRID_MAX_COLS);
      phase_plan[p].rows = ($urandom << CNT_W) | $urandom_range(1, GRID_MAX_ROWS);
      phase_plan[p].col_pitch = $urandom_range(1, 4096);
      phase_plan[p].row_pitch = $urandom_range(0, 4096);
      phase_plan[p].x_extent = $urandom_range(0, 8191);
      phase_plan[p].y_extent = $urandom_range(0, 8191);
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end
    for (p = 0; p < NUM_PHASES; p++) begin
      apply_setup(phase_plan[p]);
      repeat (PHASE_ITEMS) send_item(random_item(), 1'b0, '0);
    end
    start <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
